// File: design/ring_hodoscope_hit_tile_histogram_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ring hodoscope hit tile histogram unit
// Shorthand for clocked property checks; expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RING_HODOSCOPE_HIT_TILE_HISTOGRAM_UNIT_MACROS_SVH
`define RING_HODOSCOPE_HIT_TILE_HISTOGRAM_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define RHTH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define RHTH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also checks through reset
`define RHTH_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rhth_pkg.sv
// ----------------------------------------------------------------------------
// rhth_pkg
// Constants, codes and shared types of the ring hit tile histogram.
// ----------------------------------------------------------------------------
package rhth_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int NTILES      = 34;
  localparam int TILE_W      = $clog2(NTILES);
  localparam int POS_W       = 16;
  localparam int OUT_CNT_W   = 32;
  localparam int TOL_W       = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  // geometry in 1/16 mm
  localparam int RING_R   = 5392;
  localparam int CENTRE_Y = 192;
  localparam int PITCH    = 1088;
  localparam int Q16_DIAG = 46341;

  // projection word: 17-bit sum times Q16 coefficient, plus margin
  localparam int PW = 34;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  localparam logic FUNC_HIT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIAL_TOL  = 3'd0,
    CFG_RING_SIDE   = 3'd1,
    CFG_PLANE_ROT   = 3'd2,
    CFG_MIRROR      = 3'd3,
    CFG_UNIQUE      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [TOL_W-1:0] tol;
    logic             side;
    logic [2:0]       rot;
    logic             mir;
    logic             uniq;
  } cfg_t;

  // mapped hit handed from the geometry pipe to the histogram
  typedef struct packed {
    logic              vld;
    logic              func;
    logic              new_event;
    logic [TILE_W-1:0] read_bin;
    logic              ok;
    logic [2:0]        plane;
    logic [1:0]        bar;
    logic              ypos;
  } geom_t;

endpackage

// File: design/rhth_ifs.sv
// ----------------------------------------------------------------------------
// rhth channel interfaces
// Valid/ready channels for hit requests, results and register writes.
// ----------------------------------------------------------------------------
interface rhth_in_if import rhth_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic                    new_event;
  logic [TILE_W-1:0]       read_bin;

  modport source (output valid, func, pos_x, pos_y, pos_z, new_event, read_bin,
                  input ready);
  modport sink   (input valid, func, pos_x, pos_y, pos_z, new_event, read_bin,
                  output ready);
endinterface

interface rhth_out_if import rhth_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [TILE_W-1:0]    tile;
  logic                 counted;
  logic [OUT_CNT_W-1:0] bin_count;

  modport source (output valid, accepted, tile, counted, bin_count, input ready);
  modport sink   (input valid, accepted, tile, counted, bin_count, output ready);
endinterface

interface rhth_cfg_if import rhth_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/rhth_ram.sv
// ----------------------------------------------------------------------------
// rhth_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rhth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 34,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/rhth_geom.sv
// ----------------------------------------------------------------------------
// rhth_geom
// Input register, plane projections, radius window and nearest-plane pick.
// ----------------------------------------------------------------------------
module rhth_geom import rhth_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  rhth_in_if.sink in_ch,
  input  logic   c_free,
  output geom_t  c_o
);

  localparam logic signed [PW-1:0]    DIAG_S   = PW'(Q16_DIAG);
  localparam logic signed [PW-1:0]    RING_Q   = PW'(RING_R * 65536);
  localparam logic signed [PW-1:0]    PITCH_Q  = PW'(PITCH * 65536);
  localparam logic signed [POS_W-1:0] CENTRE_S = POS_W'(CENTRE_Y);

  // bar index: thresholds reached or passed by the tangential coordinate
  function automatic logic [1:0] bar_of(input logic signed [PW-1:0] t);
    logic [1:0] n;
    n = {1'b0, t >= -PITCH_Q} + {1'b0, t >= 0} + {1'b0, t >= PITCH_Q};
    return n;
  endfunction

  // ---------------- stage A: input register
  logic                    a_vld_r, a_func_r, a_ne_r;
  logic signed [POS_W-1:0] a_x_r, a_y_r, a_z_r;
  logic [TILE_W-1:0]       a_bin_r;

  // ---------------- stage B: products
  logic                    b_vld_r, b_func_r, b_ne_r, b_ypos_r;
  logic [TILE_W-1:0]       b_bin_r;
  logic signed [POS_W-1:0] b_x_r, b_z_r;
  logic signed [PW-1:0]    b_ps_r, b_pd_r;
  logic [31:0]             b_sqx_r, b_sqz_r;

  // ---------------- stage C: mapped hit
  geom_t c_r, c_nxt;

  logic a_free, b_free, c_free_l;

  assign c_free_l    = !c_r.vld || c_free;
  assign b_free      = !b_vld_r || c_free_l;
  assign a_free      = !a_vld_r || b_free;
  assign in_ch.ready = a_free;
  assign c_o         = c_r;

  // radius window bounds, refreshed from the registers every cycle
  logic [13:0] hi_w;
  logic [12:0] lo_w;
  logic [27:0] hi2_r;
  logic [25:0] lo2_r;
  logic        lo_pos_r, tol_zero_r;

  assign hi_w = 14'(RING_R) + 14'(cfg.tol);
  assign lo_w = 13'(RING_R) - 13'(cfg.tol);

  always_ff @(posedge clk) begin
    hi2_r      <= 28'(hi_w) * 28'(hi_w);
    lo2_r      <= 26'(lo_w) * 26'(lo_w);
    lo_pos_r   <= 14'(cfg.tol) < 14'(RING_R);
    tol_zero_r <= cfg.tol == '0;
  end

  // ---------------- A -> B
  logic signed [POS_W:0] s_w, d_w;
  assign s_w = {a_x_r[POS_W-1], a_x_r} + {a_z_r[POS_W-1], a_z_r};
  assign d_w = {a_x_r[POS_W-1], a_x_r} - {a_z_r[POS_W-1], a_z_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_free)   a_vld_r <= in_ch.valid;
      if (b_free)   b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_func_r <= in_ch.func;
      a_x_r    <= in_ch.pos_x;
      a_y_r    <= in_ch.pos_y;
      a_z_r    <= in_ch.pos_z;
      a_ne_r   <= in_ch.new_event;
      a_bin_r  <= in_ch.read_bin;
    end
    if (b_free) begin
      b_func_r <= a_func_r;
      b_ne_r   <= a_ne_r;
      b_bin_r  <= a_bin_r;
      b_ypos_r <= a_y_r > CENTRE_S;
      b_x_r    <= a_x_r;
      b_z_r    <= a_z_r;
      b_ps_r   <= PW'(s_w) * DIAG_S;
      b_pd_r   <= PW'(d_w) * DIAG_S;
      b_sqx_r  <= 32'($signed(32'(a_x_r)) * $signed(32'(a_x_r)));
      b_sqz_r  <= 32'($signed(32'(a_z_r)) * $signed(32'(a_z_r)));
    end
  end

  // stage C register: only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else if (c_free_l) begin
      c_r.vld <= c_nxt.vld;
    end
    if (c_free_l) begin
      c_r.func      <= c_nxt.func;
      c_r.new_event <= c_nxt.new_event;
      c_r.read_bin  <= c_nxt.read_bin;
      c_r.ok        <= c_nxt.ok;
      c_r.plane     <= c_nxt.plane;
      c_r.bar       <= c_nxt.bar;
      c_r.ypos      <= c_nxt.ypos;
    end
  end

  // ---------------- B -> C
  logic signed [PW-1:0] xq, zq, tgt;
  logic signed [PW-1:0] zl [8];
  logic signed [PW-1:0] tl [8];
  logic signed [PW-1:0] diff [8];
  logic [PW-1:0]        dabs [8];
  logic [PW-1:0]        v1 [4];
  logic [2:0]           i1 [4];
  logic [PW-1:0]        v2 [2];
  logic [2:0]           i2 [2];
  logic [2:0]           best;
  logic [31:0]          r2;
  logic                 rad_ok;

  assign xq  = {{(PW-POS_W-16){b_x_r[POS_W-1]}}, b_x_r, 16'b0};
  assign zq  = {{(PW-POS_W-16){b_z_r[POS_W-1]}}, b_z_r, 16'b0};
  assign tgt = cfg.side ? -RING_Q : RING_Q;

  // radial (zl) and tangential (tl) coordinates of the eight planes
  always_comb begin
    zl[0] = zq;       tl[0] = xq;
    zl[1] = b_ps_r;   tl[1] = b_pd_r;
    zl[2] = xq;       tl[2] = -zq;
    zl[3] = b_pd_r;   tl[3] = -b_ps_r;
    zl[4] = -zq;      tl[4] = -xq;
    zl[5] = -b_ps_r;  tl[5] = -b_pd_r;
    zl[6] = -xq;      tl[6] = zq;
    zl[7] = -b_pd_r;  tl[7] = b_ps_r;
    for (int k = 0; k < 8; k++) begin
      diff[k] = zl[k] - tgt;
      dabs[k] = diff[k][PW-1] ? PW'(-diff[k]) : PW'(diff[k]);
    end
  end

  // argmin tree; the left (lower) index keeps ties
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (dabs[2*k+1] < dabs[2*k]) begin
        v1[k] = dabs[2*k+1];
        i1[k] = 3'(2*k+1);
      end else begin
        v1[k] = dabs[2*k];
        i1[k] = 3'(2*k);
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (v1[2*k+1] < v1[2*k]) begin
        v2[k] = v1[2*k+1];
        i2[k] = i1[2*k+1];
      end else begin
        v2[k] = v1[2*k];
        i2[k] = i1[2*k];
      end
    end
    best = (v2[1] < v2[0]) ? i2[1] : i2[0];
  end

  assign r2     = b_sqx_r + b_sqz_r;
  assign rad_ok = tol_zero_r ||
                  ((r2 <= 32'(hi2_r)) && (!lo_pos_r || r2 >= 32'(lo2_r)));

  always_comb begin
    c_nxt.vld       = b_vld_r;
    c_nxt.func      = b_func_r;
    c_nxt.new_event = b_ne_r;
    c_nxt.read_bin  = b_bin_r;
    c_nxt.ok        = rad_ok;
    c_nxt.plane     = best;
    c_nxt.bar       = bar_of(tl[best]);
    c_nxt.ypos      = b_ypos_r;
  end

endmodule

// File: design/rhth_hist.sv
// ----------------------------------------------------------------------------
// rhth_hist
// Tile map, count memory read-modify-write, seen-tile mask, result register.
// ----------------------------------------------------------------------------
module rhth_hist import rhth_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  geom_t   c_i,
  output logic    c_free,
  rhth_out_if.source out_ch
);

  // ---------------- tile map of the hit in stage C
  logic [2:0]        plane;
  logic [1:0]        bar;
  logic [TILE_W-1:0] tile_w;
  logic              bin_ok;
  logic [TILE_W-1:0] rd_addr;

  assign plane  = c_i.plane + cfg.rot;
  assign bar    = cfg.mir ? ~c_i.bar : c_i.bar;
  assign bin_ok = c_i.read_bin < TILE_W'(NTILES);

  always_comb begin
    if (plane == 3'd0) begin
      case (bar)
        2'd0:    tile_w = TILE_W'(0);
        2'd1:    tile_w = c_i.ypos ? TILE_W'(1) : TILE_W'(2);
        2'd2:    tile_w = c_i.ypos ? TILE_W'(3) : TILE_W'(4);
        default: tile_w = TILE_W'(5);
      endcase
    end else begin
      tile_w = {plane, 2'b00} + TILE_W'(bar) + TILE_W'(2);
    end
  end

  always_comb begin
    if (c_i.func == FUNC_READ) begin
      rd_addr = bin_ok ? c_i.read_bin : '0;
    end else begin
      rd_addr = tile_w;
    end
  end

  // ---------------- stage D: count read back
  logic                   d_vld_r, d_func_r, d_ne_r, d_ok_r, d_bin_ok_r;
  logic [TILE_W-1:0]      d_tile_r;
  logic                   d_vbit_r, d_byp_r;
  logic [COUNT_WIDTH-1:0] d_byp_cnt_r;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [NTILES-1:0]      vbits_r;
  logic [NTILES-1:0]      seen_r, seen_nxt;

  // ---------------- stage E: result register
  logic                 out_vld_r;
  logic                 out_acc_r, out_cnt_r;
  logic [TILE_W-1:0]    out_tile_r;
  logic [OUT_CNT_W-1:0] out_bin_r;

  logic e_take, d_adv, d_free;

  assign e_take = !out_vld_r || out_ch.ready;
  assign d_free = !d_vld_r || e_take;
  assign d_adv  = d_vld_r && e_take;
  assign c_free = d_free;

  // ---------------- count update
  logic [COUNT_WIDTH-1:0] cur, new_cnt;
  logic [NTILES-1:0]      mask, bit_w;
  logic                   is_hit, hit_ok, dup, cnt_inc, wr_en;

  assign cur     = d_byp_r ? d_byp_cnt_r : (d_vbit_r ? rd_data : '0);
  assign is_hit  = d_func_r == FUNC_HIT;
  assign hit_ok  = is_hit && d_ok_r;
  assign mask    = d_ne_r ? '0 : seen_r;
  assign bit_w   = NTILES'(1) << d_tile_r;
  assign dup     = cfg.uniq && |(mask & bit_w);
  assign cnt_inc = hit_ok && !dup && (cur != CNT_MAX);
  assign new_cnt = cnt_inc ? cur + COUNT_WIDTH'(1) : cur;
  assign wr_en   = d_adv && cnt_inc;

  always_comb begin
    seen_nxt = seen_r;
    if (d_adv && is_hit) begin
      seen_nxt = mask | ((hit_ok && cfg.uniq) ? bit_w : '0);
    end
  end

  rhth_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NTILES)
  ) u_counts (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (d_tile_r),
    .wr_data (new_cnt),
    .rd_en   (d_free),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      vbits_r   <= '0;
      seen_r    <= '0;
    end else begin
      if (d_free) d_vld_r   <= c_i.vld;
      if (e_take) out_vld_r <= d_vld_r;
      if (wr_en)  vbits_r[d_tile_r] <= 1'b1;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (d_free) begin
      d_func_r    <= c_i.func;
      d_ne_r      <= c_i.new_event;
      d_ok_r      <= c_i.ok;
      d_bin_ok_r  <= bin_ok;
      d_tile_r    <= rd_addr;
      d_vbit_r    <= vbits_r[rd_addr];
      // write leaving D on this edge is not yet visible in the read data
      d_byp_r     <= wr_en && (d_tile_r == rd_addr);
      d_byp_cnt_r <= new_cnt;
    end
    if (e_take) begin
      out_acc_r  <= hit_ok;
      out_cnt_r  <= cnt_inc;
      out_tile_r <= hit_ok ? d_tile_r : '0;
      if (is_hit) begin
        out_bin_r <= hit_ok ? OUT_CNT_W'(new_cnt) : '0;
      end else begin
        out_bin_r <= d_bin_ok_r ? OUT_CNT_W'(cur) : '0;
      end
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.accepted  = out_acc_r;
  assign out_ch.tile      = out_tile_r;
  assign out_ch.counted   = out_cnt_r;
  assign out_ch.bin_count = out_bin_r;

endmodule

// File: design/ring_hodoscope_hit_tile_histogram_unit.sv
// ----------------------------------------------------------------------------
// ring_hodoscope_hit_tile_histogram_unit
// Maps ring detector hits to tiles and keeps a per-tile hit histogram.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one request per item. func = 0 is a hit (pos_x/y/z in 1/16 mm,
//            new_event marks the first hit of an event); func = 1 reads
//            histogram bin read_bin.
//   out_ch : one result per request, in request order: accepted, tile,
//            counted and bin_count.
//   cfg_ch : register writes (index, data), always ready; write only while
//            no request is in flight.
// Pipeline: a request passes the input, product, map, count-read and result
//   registers in that order before its result shows on out_ch.
// Throughput: one request per cycle while out_ch is not held off; the read-modify-write
//   of the 34-entry count RAM forwards back-to-back hits on one tile.
// Reset: sync, active low. Clears registers to defaults, the pipeline valids,
//   the seen-tile mask and the per-tile valid bits, so every bin reads zero
//   right away; no clearing pass.
// Stall: when out_ch is held off the result register keeps its request and
//   the pipeline keeps filling its empty stages; in_ch backs off only once
//   all stages hold a request.
// ----------------------------------------------------------------------------
module ring_hodoscope_hit_tile_histogram_unit import rhth_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rhth_cfg_if.sink    cfg_ch,
  rhth_in_if.sink     in_ch,
  rhth_out_if.source  out_ch
);

  // ---------------- configuration registers
  cfg_t cfg_r, cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_RADIAL_TOL: cfg_nxt.tol  = cfg_ch.data;
        CFG_RING_SIDE:  cfg_nxt.side = cfg_ch.data[0];
        CFG_PLANE_ROT:  cfg_nxt.rot  = cfg_ch.data[2:0];
        CFG_MIRROR:     cfg_nxt.mir  = cfg_ch.data[0];
        CFG_UNIQUE:     cfg_nxt.uniq = cfg_ch.data[0];
        default:        cfg_nxt = cfg_r;   // unused indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tol  <= TOL_W'(400);
      cfg_r.side <= 1'b0;
      cfg_r.rot  <= 3'd0;
      cfg_r.mir  <= 1'b0;
      cfg_r.uniq <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- geometry pipe -> histogram
  geom_t geom;
  logic  geom_free;

  rhth_geom u_geom (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .c_free (geom_free),
    .c_o    (geom)
  );

  rhth_hist u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .c_i    (geom),
    .c_free (geom_free),
    .out_ch (out_ch)
  );

endmodule

// File: design/rhth_checker.sv
// ----------------------------------------------------------------------------
// rhth_checker
// Port-level checks of the tile histogram unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "ring_hodoscope_hit_tile_histogram_unit_macros.svh"

module rhth_checker import rhth_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_accepted,
  input logic [TILE_W-1:0]    out_tile,
  input logic                 out_counted,
  input logic [OUT_CNT_W-1:0] out_bin_count
);

  // whole result payload, for the hold check
  logic [OUT_CNT_W+TILE_W+1:0] out_pay;
  assign out_pay = {out_accepted, out_tile, out_counted, out_bin_count};

  // nothing comes out of the pipe right after reset
  `RHTH_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result valid after reset")

  // with the result register empty every stage can move, so input is taken
  `RHTH_ASSERT_IMP(a_idle_ready, !out_valid, in_ready, "input held off with empty output")

  // a stalled result holds
  `RHTH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pay), "result moved")

  // with no request offered and no result waiting, the input stage is left empty and open
  `RHTH_ASSERT_NXT(a_fill_ready, !in_valid && !out_valid, in_ready, "input held off after idle")

endmodule

bind ring_hodoscope_hit_tile_histogram_unit rhth_checker u_rhth_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_accepted  (out_ch.accepted),
  .out_tile      (out_ch.tile),
  .out_counted   (out_ch.counted),
  .out_bin_count (out_ch.bin_count)
);

// File: tb/ring_hodoscope_hit_tile_histogram_unit_tb.sv
// ----------------------------------------------------------------------------
// ring_hodoscope_hit_tile_histogram_unit_tb
// Self-checking bench: drives hit and bin-read requests through the valid/ready
// channels, predicts radius cut, plane/bar mapping and the per-tile histogram
// in a local model, and compares every result field in request order. Runs
// several register settings, including the extremes, with random back-pressure.
// ----------------------------------------------------------------------------
module ring_hodoscope_hit_tile_histogram_unit_tb;
  import rhth_pkg::*;

  localparam longint Q16_ONE        = 65536;
  localparam int     WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int     PHASE_ITEMS    = 150;   // random requests per setting
  localparam int     DRAIN_CYCLES   = 8;     // drains the input, product, map, count-read and result stages
  localparam int     MAX_REPORTS    = 10;
  localparam int     HOLD_AT        = 250;   // results seen before the long hold
  localparam int     LONG_HOLD      = 80;    // far longer than the pipeline

  // one request on in_ch
  typedef struct {
    logic                    func;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    new_event;
    logic [TILE_W-1:0]       read_bin;
  } hit_req_t;

  // one result on out_ch
  typedef struct {
    logic                 accepted;
    logic [TILE_W-1:0]    tile;
    logic                 counted;
    logic [OUT_CNT_W-1:0] bin_count;
  } tile_result_t;

  logic clk = 1'b0;
  logic rst_n;

  rhth_cfg_if cfg_ch ();
  rhth_in_if  in_ch ();
  rhth_out_if out_ch ();

  ring_hodoscope_hit_tile_histogram_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local copy of the histogram state and register settings
  // --------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] tile_counts [NTILES];
  logic [NTILES-1:0]      seen_mask;
  cfg_t                   cur_cfg;

  hit_req_t     pending_reqs [$];     // filled by the sequence, drained by driver
  tile_result_t expected_results [$]; // one per accepted request, oldest first

  int unsigned offered_reqs;   // driver side
  int unsigned taken_reqs;     // handshake side
  int unsigned results_seen;
  int unsigned fail_cnt;
  int unsigned quiet_cycles;
  bit          idle_en;        // random gaps on both channels
  bit          rx_holding;     // receiver is in its long hold
  int          tx_gap;
  int          rx_gap;
  int          hold_left;
  bit          hold_done;
  hit_req_t    last_hit;
  bit          have_last;

  // Q16 cosine of k * 45 degrees; the sine is the same table shifted by 6
  function automatic longint q16_axis(int k);
    case (k & 7)
      0:       return Q16_ONE;
      1, 7:    return Q16_DIAG;
      2, 6:    return 0;
      3, 5:    return -Q16_DIAG;
      default: return -Q16_ONE;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: radius cut, nearest plane, bar, tile, histogram update
  // --------------------------------------------------------------------------
  function automatic tile_result_t predict_tile_hit(hit_req_t rq);
    tile_result_t res;
    longint       lx, ly, lz, r2, hi, lo, target, zl, sep, best_sep, best_t;
    int           best, plane, bar, tl;
    res = '{accepted: 1'b0, tile: '0, counted: 1'b0, bin_count: '0};
    if (rq.func == FUNC_READ) begin
      // new_event is ignored on reads; bins past the last tile read zero
      if (rq.read_bin < NTILES) res.bin_count = OUT_CNT_W'(tile_counts[rq.read_bin]);
      return res;
    end
    // a new event clears the mask even when the hit itself is rejected
    if (rq.new_event) seen_mask = '0;
    lx = longint'(rq.pos_x);
    ly = longint'(rq.pos_y) - CENTRE_Y;
    lz = longint'(rq.pos_z);
    // radius window on squared values; zero tolerance turns the cut off
    r2 = lx * lx + lz * lz;
    hi = RING_R + longint'(cur_cfg.tol);
    lo = RING_R - longint'(cur_cfg.tol);
    if (cur_cfg.tol != 0 && (r2 > hi * hi || (lo > 0 && r2 < lo * lo))) return res;
    target = longint'(RING_R) * Q16_ONE;
    if (cur_cfg.side) target = -target;
    best = 0;
    best_sep = 0;
    best_t = 0;
    // strict compare: lowest plane index wins a tie
    for (int k = 0; k < 8; k++) begin
      zl = lx * q16_axis(k + 6) + lz * q16_axis(k);
      sep = zl - target;
      if (sep < 0) sep = -sep;
      if (k == 0 || sep < best_sep) begin
        best_sep = sep;
        best = k;
        best_t = lx * q16_axis(k) - lz * q16_axis(k + 6);
      end
    end
    plane = (best + int'(cur_cfg.rot)) % 8;
    bar = 0;
    if (best_t >= -longint'(PITCH) * Q16_ONE) bar++;
    if (best_t >= 0) bar++;
    if (best_t >= longint'(PITCH) * Q16_ONE) bar++;
    if (cur_cfg.mir) bar = 3 - bar;
    if (plane == 0) begin
      // middle bars of plane 0 are split by the sign of centred y
      case (bar)
        0:       tl = 0;
        1:       tl = (ly > 0) ? 1 : 2;
        2:       tl = (ly > 0) ? 3 : 4;
        default: tl = 5;
      endcase
    end else begin
      tl = plane * 4 + bar + 2;
    end
    res.accepted = 1'b1;
    res.tile = TILE_W'(tl);
    if (!cur_cfg.uniq || !seen_mask[tl]) begin
      if (cur_cfg.uniq) seen_mask[tl] = 1'b1;
      if (tile_counts[tl] != CNT_MAX) begin
        tile_counts[tl] = tile_counts[tl] + 1'b1;
        res.counted = 1'b1;
      end
    end
    res.bin_count = OUT_CNT_W'(tile_counts[tl]);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request builders
  // --------------------------------------------------------------------------
  function automatic hit_req_t hit_at(longint x, longint y, longint z, logic ne);
    hit_req_t rq;
    rq.func      = FUNC_HIT;
    rq.pos_x     = POS_W'(x);
    rq.pos_y     = POS_W'(y);
    rq.pos_z     = POS_W'(z);
    rq.new_event = ne;
    rq.read_bin  = TILE_W'($urandom);
    return rq;
  endfunction

  function automatic hit_req_t bin_read(int bin, logic ne);
    hit_req_t rq;
    rq.func      = FUNC_READ;
    rq.pos_x     = POS_W'($urandom);
    rq.pos_y     = POS_W'($urandom);
    rq.pos_z     = POS_W'($urandom);
    rq.new_event = ne;
    rq.read_bin  = TILE_W'(bin);
    return rq;
  endfunction

  // hit near the ring: random plane, radial offset, tangential position
  function automatic hit_req_t ring_hit(logic ne);
    longint r, t, x, y, z;
    int     k;
    k = $urandom_range(0, 7);
    r = longint'(RING_R) + longint'($urandom_range(0, 1400)) - 700;
    if ($urandom_range(0, 3) == 0) r = -r;
    if ($urandom_range(0, 3) == 0) begin
      // right on a bar edge, a few units either way
      t = longint'(PITCH) * (longint'($urandom_range(0, 2)) - 1)
        + longint'($urandom_range(0, 4)) - 2;
    end else begin
      t = longint'($urandom_range(0, 5000)) - 2500;
    end
    x = (r * q16_axis(k + 6) + t * q16_axis(k)) >>> 16;
    z = (r * q16_axis(k) - t * q16_axis(k + 6)) >>> 16;
    if ($urandom_range(0, 3) == 0) y = CENTRE_Y + longint'($urandom_range(0, 4)) - 2;
    else y = longint'($signed(POS_W'($urandom)));
    return hit_at(x, y, z, ne);
  endfunction

  // mostly well-formed events of ring hits, some repeats, reads and noise
  function automatic hit_req_t next_random_req();
    hit_req_t rq;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      rq = bin_read($urandom_range(0, 63), 1'($urandom_range(0, 1)));
    end else if (pick < 20) begin
      rq = bin_read(0, 1'b0);
      rq.func      = 1'($urandom_range(0, 1));
      rq.new_event = 1'($urandom_range(0, 1));
      rq.read_bin  = TILE_W'($urandom);
    end else if (pick < 32 && have_last) begin
      rq = last_hit;
      rq.new_event = 1'b0;
    end else begin
      rq = ring_hit($urandom_range(0, 4) == 0);
    end
    if (rq.func == FUNC_HIT) begin
      last_hit = rq;
      have_last = 1'b1;
    end
    return rq;
  endfunction

  // --------------------------------------------------------------------------
  // Sequence helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_RADIAL_TOL: cur_cfg.tol  = val[TOL_W-1:0];
      CFG_RING_SIDE:  cur_cfg.side = val[0];
      CFG_PLANE_ROT:  cur_cfg.rot  = val[2:0];
      CFG_MIRROR:     cur_cfg.mir  = val[0];
      CFG_UNIQUE:     cur_cfg.uniq = val[0];
      default: ;      // unused index: no effect
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_settings(input int tol, input bit side, input int rot,
                                input bit mir, input bit uniq);
    write_reg(CFG_RADIAL_TOL, CFG_DATA_W'(tol));
    write_reg(CFG_RING_SIDE, CFG_DATA_W'(side));
    write_reg(CFG_PLANE_ROT, CFG_DATA_W'(rot));
    write_reg(CFG_MIRROR, CFG_DATA_W'(mir));
    write_reg(CFG_UNIQUE, CFG_DATA_W'(uniq));
  endtask

  task automatic queue_random(input int n);
    @(posedge clk);
    repeat (n) pending_reqs.push_back(next_random_req());
  endtask

  // idle = nothing queued, nothing offered, nothing outstanding
  task automatic wait_drained();
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued requests at the falling edge, random gaps between
  // requests; valid never drops while a request waits for ready
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    hit_req_t rq;
    bit       drive_new;
    if (rst_n) begin
      if (tx_gap > 0) tx_gap--;
      if (!in_ch.valid || taken_reqs == offered_reqs) begin
        drive_new = 1'b0;
        if (tx_gap == 0 && pending_reqs.size() != 0) begin
          // keep offering during the receiver's long hold so the pipe fills
          if (idle_en && !rx_holding && $urandom_range(0, 5) == 0) begin
            tx_gap = $urandom_range(1, 17);
          end else begin
            rq = pending_reqs.pop_front();
            drive_new = 1'b1;
            offered_reqs++;
          end
        end
        if (drive_new) begin
          in_ch.valid     <= 1'b1;
          in_ch.func      <= rq.func;
          in_ch.pos_x     <= rq.pos_x;
          in_ch.pos_y     <= rq.pos_y;
          in_ch.pos_z     <= rq.pos_z;
          in_ch.new_event <= rq.new_event;
          in_ch.read_bin  <= rq.read_bin;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver ready: random stall bursts, plus one long hold once enough
  // results have come back
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    bit rdy;
    if (rst_n) begin
      rdy = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        rdy = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rdy = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(1, 17) - 1;
        rdy = 1'b0;
      end
      out_ch.ready <= rdy;
      rx_holding   <= (hold_left > 0);
    end
  end

  // --------------------------------------------------------------------------
  // Rising edge: predict each accepted request, check each result, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    hit_req_t     rq;
    tile_result_t want;
    bit           busy;
    if (rst_n) begin
      busy = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        rq.func      = in_ch.func;
        rq.pos_x     = in_ch.pos_x;
        rq.pos_y     = in_ch.pos_y;
        rq.pos_z     = in_ch.pos_z;
        rq.new_event = in_ch.new_event;
        rq.read_bin  = in_ch.read_bin;
        expected_results.push_back(predict_tile_hit(rq));
        taken_reqs++;
        busy = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        busy = 1'b1;
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("unexpected result: accepted=%0d tile=%0d counted=%0d count=%0d",
                     out_ch.accepted, out_ch.tile, out_ch.counted, out_ch.bin_count);
        end else begin
          want = expected_results.pop_front();
          if (want.accepted !== out_ch.accepted || want.tile !== out_ch.tile ||
              want.counted !== out_ch.counted || want.bin_count !== out_ch.bin_count) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS) begin
              $display("mismatch at result %0d: exp acc=%0d tile=%0d cnt=%0d count=%0d",
                       results_seen, want.accepted, want.tile, want.counted,
                       want.bin_count);
              $display("  got acc=%0d tile=%0d cnt=%0d count=%0d",
                       out_ch.accepted, out_ch.tile, out_ch.counted, out_ch.bin_count);
            end
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) busy = 1'b1;
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: directed requests at reset settings, then one random phase per
  // register setting; registers change only once the pipe has drained
  // --------------------------------------------------------------------------
  initial begin
    longint y_up, y_dn;
    y_up = CENTRE_Y + 100;
    y_dn = CENTRE_Y - 100;

    rst_n = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_HIT;
    in_ch.pos_x     = '0;
    in_ch.pos_y     = '0;
    in_ch.pos_z     = '0;
    in_ch.new_event = 1'b0;
    in_ch.read_bin  = '0;
    out_ch.ready = 1'b0;
    for (int k = 0; k < NTILES; k++) tile_counts[k] = '0;
    seen_mask = '0;
    cur_cfg = '{tol: 12'd400, side: 1'b0, rot: 3'd0, mir: 1'b0, uniq: 1'b1};
    idle_en = 1'b1;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: bar edges on plane 0, y split, radius window edges,
    // repeat in an event, mask cleared by a rejected hit, reads
    @(posedge clk);
    pending_reqs.push_back(bin_read(0, 1'b1));                      // read ignores new_event
    pending_reqs.push_back(hit_at(-PITCH - 1, y_up, RING_R, 1'b1)); // bar 0
    pending_reqs.push_back(hit_at(-PITCH, y_up, RING_R, 1'b0));     // bar 1, y above
    pending_reqs.push_back(hit_at(-PITCH, CENTRE_Y, RING_R, 1'b0)); // bar 1, y on centre
    pending_reqs.push_back(hit_at(-1, y_dn, RING_R, 1'b0));         // same tile again
    pending_reqs.push_back(hit_at(0, CENTRE_Y + 1, RING_R, 1'b0));  // bar 2, y above
    pending_reqs.push_back(hit_at(PITCH - 1, y_dn, RING_R, 1'b0));  // bar 2, y below
    pending_reqs.push_back(hit_at(PITCH, y_up, RING_R, 1'b0));      // bar 3
    pending_reqs.push_back(hit_at(PITCH, y_up, RING_R, 1'b0));      // seen in event
    pending_reqs.push_back(hit_at(0, y_up, RING_R + 401, 1'b1));    // too far, clears mask
    pending_reqs.push_back(hit_at(0, y_up, RING_R + 400, 1'b0));    // outer edge
    pending_reqs.push_back(hit_at(0, y_dn, RING_R - 400, 1'b0));    // inner edge
    pending_reqs.push_back(hit_at(0, y_dn, RING_R - 401, 1'b0));    // too close
    pending_reqs.push_back(hit_at(RING_R, y_dn, 0, 1'b0));          // plane 2
    pending_reqs.push_back(hit_at(3813, y_dn, 3813, 1'b0));         // diagonal plane
    pending_reqs.push_back(hit_at(0, y_dn, -RING_R, 1'b0));         // opposite plane
    pending_reqs.push_back(hit_at(-3813, y_dn, -3813, 1'b0));
    pending_reqs.push_back(hit_at(-32768, -32768, 32767, 1'b1));    // field extremes
    pending_reqs.push_back(hit_at(32767, 32767, -32768, 1'b0));
    pending_reqs.push_back(bin_read(NTILES - 1, 1'b0));
    pending_reqs.push_back(bin_read(NTILES, 1'b0));                 // past the last tile
    pending_reqs.push_back(bin_read(63, 1'b0));
    queue_random(PHASE_ITEMS);
    wait_drained();

    // no radius cut, minus side, rotated and mirrored, every hit counted
    apply_settings(0, 1'b1, 3, 1'b1, 1'b0);
    for (int k = int'(CFG_UNIQUE) + 1; k < 2 ** CFG_IDX_W; k++)
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));              // must be ignored
    @(posedge clk);
    pending_reqs.push_back(hit_at(0, CENTRE_Y, 0, 1'b1));          // origin: all planes tie
    pending_reqs.push_back(hit_at(-32768, -32768, -32768, 1'b0));
    pending_reqs.push_back(hit_at(32767, 32767, 32767, 1'b0));
    pending_reqs.push_back(hit_at(32767, 32767, 32767, 1'b0));     // counted twice
    queue_random(PHASE_ITEMS);
    wait_drained();

    apply_settings(4095, 1'b0, 7, 1'b0, 1'b1);                     // widest window
    queue_random(PHASE_ITEMS);
    wait_drained();

    apply_settings(1, 1'b1, 0, 1'b1, 1'b1);                        // narrowest window
    queue_random(PHASE_ITEMS);
    wait_drained();

    apply_settings($urandom_range(1, 4095), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    queue_random(PHASE_ITEMS);
    wait_drained();

    apply_settings(400, 1'b0, 5, 1'b0, 1'b0);
    queue_random(PHASE_ITEMS);
    wait_drained();

    // last stretch at full rate on both sides
    apply_settings(200, 1'b0, 0, 1'b0, 1'b1);
    idle_en = 1'b0;
    queue_random(PHASE_ITEMS);
    wait_drained();

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
